### rtl/theq_pkg.sv
// shared constants for the thresholded histogram equalizer
package theq_pkg;

  localparam int NUM_BINS = 256;
  localparam int PIX_W    = 8;
  localparam int QUOT_W   = 8;

  // configuration register indexes
  localparam logic [1:0] REG_MEAN_LIMIT = 2'd0;
  localparam logic [1:0] REG_ZERO_FLOOR = 2'd1;
  localparam logic [1:0] REG_LOW_BOUND  = 2'd2;
  localparam logic [1:0] REG_HIGH_BOUND = 2'd3;

  // operation codes
  localparam logic OP_GATHER = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/theq_div.sv
// restoring divider, one quotient bit per cycle, 8-bit quotient
module theq_div #(
  parameter int W = 29
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output theq_pkg::div_status_t status,
  output logic [theq_pkg::QUOT_W-1:0] quot
);
  import theq_pkg::*;

  logic [W-1:0]        rem;
  logic [W-1:0]        dsh;
  logic [2:0]          step;
  logic                busy;
  logic                done;
  logic                fits;

  // trial subtract of the shifted divisor
  assign fits = (rem >= dsh);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd7;
      end else if (busy) begin
        step <= step - 3'd1;
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient is known to stay below 256
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= den << 7;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

### rtl/thresholded_histogram_equalizer.sv
// top level: histogram gather, remap table build and pixel remap
//
// Gather transfers (operation 0) pass through a histogram write state and
// yield no result; the pixel is not counted when the frame already holds
// MAX_FRAME_PIXELS pixels. A map transfer (operation 1) has its result
// registered in the map wait state, which waits while an earlier result is
// still held. After reset a clearing pass zeroes the histogram and loads the
// identity table; no item is accepted meanwhile. The gather with last_pixel
// set starts the table build, run on one shared multiplier and a bit-serial
// divider: the mean check, the first nonzero bin search, a pass over the
// band to total it, then a pass over all bins that writes the table, with a
// multiply, divider start and 8 divide steps per bin inside a nonempty band.
// The build also clears the histogram for the next frame; in_ready stays low
// while it runs.
module thresholded_histogram_equalizer #(
  parameter int MAX_FRAME_PIXELS = 1048576
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] pixel,
  input  logic       last_pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_out,
  output logic       last_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import theq_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int SW = CW + PIX_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_PIXELS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_GWR   = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_MEANC = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PCHK  = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_CHK   = 4'd11;
  localparam logic [3:0] S_MUL   = 4'd12;
  localparam logic [3:0] S_DST   = 4'd13;
  localparam logic [3:0] S_DIV   = 4'd14;

  // configuration registers
  logic [7:0] mean_limit, zero_floor, low_bound, high_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_limit <= 8'd128;
      zero_floor <= 8'd0;
      low_bound  <= 8'd0;
      high_bound <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN_LIMIT: mean_limit <= cfg_data;
        REG_ZERO_FLOOR: zero_floor <= cfg_data;
        REG_LOW_BOUND:  low_bound  <= cfg_data;
        REG_HIGH_BOUND: high_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  logic [CW-1:0] hist [NUM_BINS];
  logic [7:0]    tab  [NUM_BINS];

  logic [3:0]    state;
  logic [7:0]    idx;
  logic [7:0]    px_r;
  logic          last_r;
  logic [CW-1:0] pixel_count;
  logic [SW-1:0] pixel_sum;
  logic [CW-1:0] pn;
  logic [CW-1:0] cum;
  logic [CW-1:0] cum_next;
  logic [SW-1:0] prod_r;
  logic [7:0]    cut_r;
  logic [7:0]    lo_r;
  logic          ident;
  logic [CW-1:0] hist_q;
  logic [7:0]    tab_q;

  logic          acc_in;
  logic [7:0]    i8;
  logic [7:0]    hist_raddr;
  logic          hist_we;
  logic [7:0]    hist_waddr;
  logic [CW-1:0] hist_wdata;
  logic          tab_we;
  logic [7:0]    tab_wdata;

  logic [CW-1:0] mul_a;
  logic [7:0]    mul_b;
  logic [SW-1:0] mul_p;
  logic [7:0]    dlt;
  logic          in_band;

  logic [7:0]    cut_c, cutf_c, lo_c;

  div_status_t           div_st;
  logic [QUOT_W-1:0]     div_quot;

  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign i8       = idx;
  assign dlt      = high_bound - lo_r;
  assign in_band  = (lo_r <= i8) && (i8 < high_bound);
  assign cum_next = cum + hist_q;

  // shared multiplier: mean limit times count, or running sum times band width
  assign mul_a = (state == S_MEAN) ? pixel_count : cum;
  assign mul_b = (state == S_MEAN) ? mean_limit : dlt;
  assign mul_p = SW'(mul_a) * SW'(mul_b);

  // cut and band start from the first nonzero bin search
  assign cut_c  = (hist_q != '0) ? i8 : 8'd0;
  assign cutf_c = (cut_c < zero_floor) ? zero_floor : cut_c;
  assign lo_c   = (low_bound > cutf_c) ? low_bound : cutf_c;

  theq_div #(.W(SW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DST),
    .num    (prod_r),
    .den    (SW'(pn)),
    .status (div_st),
    .quot   (div_quot)
  );

  // histogram port selection
  always_comb begin
    hist_raddr = (state == S_IDLE) ? pixel : i8;
    hist_we    = 1'b0;
    hist_waddr = i8;
    hist_wdata = '0;
    tab_we     = 1'b0;
    tab_wdata  = i8;
    unique case (state)
      S_INIT: begin
        hist_we = 1'b1;
        tab_we  = 1'b1;
      end
      S_GWR: begin
        hist_we    = 1'b1;
        hist_waddr = px_r;
        hist_wdata = hist_q + CW'(1);
      end
      S_CHK: begin
        hist_we = 1'b1;
        if (ident) begin
          tab_we = 1'b1;
        end else if (i8 < cut_r) begin
          tab_we    = 1'b1;
          tab_wdata = 8'd0;
        end else if (in_band) begin
          tab_we    = (pn == '0);
          tab_wdata = lo_r;
        end else begin
          tab_we = 1'b1;
        end
      end
      S_DIV: begin
        tab_we    = div_st.done;
        tab_wdata = lo_r + div_quot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hist_q <= hist[hist_raddr];
    if (hist_we) begin
      hist[hist_waddr] <= hist_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      tab_q <= tab[pixel];
    end
    if (tab_we) begin
      tab[i8] <= tab_wdata;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_MWAIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      idx         <= '0;
      pixel_count <= '0;
      pixel_sum   <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          idx <= idx + 8'd1;
          if (i8 == 8'd255) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_in) begin
            px_r   <= pixel;
            last_r <= last_pixel;
            if (operation == OP_MAP) begin
              state <= S_MWAIT;
            end else if (pixel_count < MAX_CNT) begin
              state <= S_GWR;
            end else if (last_pixel) begin
              state <= S_MEAN;
            end
          end
        end
        S_MWAIT: begin
          if (!out_valid || out_ready) begin
            pixel_out <= tab_q;
            last_out  <= last_r;
            state     <= S_IDLE;
          end
        end
        S_GWR: begin
          pixel_count <= pixel_count + CW'(1);
          pixel_sum   <= pixel_sum + SW'(px_r);
          state       <= last_r ? S_MEAN : S_IDLE;
        end
        S_MEAN: begin
          prod_r <= mul_p;
          pn     <= '0;
          cum    <= '0;
          ident  <= 1'b0;
          cut_r  <= 8'd0;
          lo_r   <= 8'd0;
          idx    <= '0;
          state  <= S_MEANC;
        end
        S_MEANC: begin
          if (pixel_sum > prod_r) begin
            ident <= 1'b1;
            state <= S_RD;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (hist_q != '0 || i8 == 8'd255) begin
            cut_r <= cutf_c;
            lo_r  <= lo_c;
            if (lo_c > high_bound) begin
              idx   <= '0;
              state <= S_RD;
            end else begin
              idx   <= lo_c;
              state <= S_PRD;
            end
          end else begin
            idx   <= idx + 8'd1;
            state <= S_SRD;
          end
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          pn <= pn + hist_q;
          if (i8 == high_bound) begin
            idx   <= '0;
            state <= S_RD;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_PRD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!ident && !(i8 < cut_r) && in_band) begin
            cum <= cum_next;
          end
          if (!ident && !(i8 < cut_r) && in_band && pn != '0) begin
            state <= S_MUL;
          end else if (i8 == 8'd255) begin
            pixel_count <= '0;
            pixel_sum   <= '0;
            idx         <= '0;
            state       <= S_IDLE;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_RD;
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          state  <= S_DST;
        end
        S_DST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            if (i8 == 8'd255) begin
              pixel_count <= '0;
              pixel_sum   <= '0;
              idx         <= '0;
              state       <= S_IDLE;
            end else begin
              idx   <= idx + 8'd1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // frame counter never runs past its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= MAX_CNT)
    else $error("pixel count above frame limit");

  // a stretched entry never leaves the band
  a_quot_in_band: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_st.done) |-> (div_quot <= dlt))
    else $error("remap step exceeds band width");

  // a result appears only out of the map wait state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_MWAIT))
    else $error("result raised outside map transfer");

  // the divider is started only when idle
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DST) |-> !div_st.busy)
    else $error("divider restarted while busy");

endmodule

### test/theq_checker.sv
// transfer monitor, remap predictor and result scoreboard for the equalizer
module theq_checker
  import theq_pkg::*;
#(
  parameter int FRAME_CAP = 1048576
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       operation,
  input  logic [7:0] pixel,
  input  logic       last_pixel,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] pixel_out,
  input  logic       last_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] px;
    logic       last;
  } mapped_pixel_t;

  // predicted copy of the registers and frame statistics
  logic [7:0]    mean_lim, floor_lvl, band_lo, band_hi;
  longint        hist [NUM_BINS];
  longint        frame_sum, frame_cnt;
  logic [7:0]    lut [NUM_BINS];
  mapped_pixel_t mapped_q [$];

  assign pending = mapped_q.size();

  // rebuild the lookup table at the end of a gather pass
  function automatic void rebuild_lut();
    int     cut, lo, hi;
    longint pn, cum, stretch;
    bit     found;
    cut = 0; pn = 0; cum = 0; found = 0;
    if (frame_sum > longint'(mean_lim) * frame_cnt) begin
      for (int i = 0; i < NUM_BINS; i++) lut[i] = 8'(i);
      return;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      if (!found && hist[i] != 0) begin
        cut = i;
        found = 1;
      end
    end
    if (cut < int'(floor_lvl)) cut = int'(floor_lvl);
    lo = (int'(band_lo) > cut) ? int'(band_lo) : cut;
    hi = int'(band_hi);
    for (int i = lo; i <= hi && i < NUM_BINS; i++) pn += hist[i];
    for (int i = 0; i < NUM_BINS; i++) begin
      if (i < cut) begin
        lut[i] = 8'd0;
      end else if (lo <= i && i < hi) begin
        cum += hist[i];
        stretch = (pn != 0) ? (cum * (hi - lo)) / pn : 0;
        lut[i] = 8'(lo + stretch);
      end else begin
        lut[i] = 8'(i);
      end
    end
  endfunction

  always @(posedge clk) begin
    mapped_pixel_t want;
    if (rst) begin
      mean_lim = 8'd128; floor_lvl = 8'd0; band_lo = 8'd0; band_hi = 8'd255;
      for (int i = 0; i < NUM_BINS; i++) begin
        hist[i] = 0;
        lut[i] = 8'(i);
      end
      frame_sum = 0; frame_cnt = 0;
      mapped_q.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_MEAN_LIMIT: mean_lim = cfg_data;
          REG_ZERO_FLOOR: floor_lvl = cfg_data;
          REG_LOW_BOUND:  band_lo = cfg_data;
          REG_HIGH_BOUND: band_hi = cfg_data;
        endcase
      end
      // result transfer against oldest prediction
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          $error("unexpected result pixel_out=%0d last_out=%0d", pixel_out, last_out);
          errors++;
        end else begin
          want = mapped_q.pop_front();
          if (pixel_out !== want.px) begin
            $error("pixel_out expected %0d actual %0d", want.px, pixel_out);
            errors++;
          end
          if (last_out !== want.last) begin
            $error("last_out expected %0d actual %0d", want.last, last_out);
            errors++;
          end
        end
      end
      // input transfer
      if (in_valid && in_ready) begin
        if (operation == OP_MAP) begin
          mapped_q.push_back('{px: lut[pixel], last: last_pixel});
        end else begin
          if (frame_cnt < FRAME_CAP) begin
            hist[pixel]++;
            frame_sum += pixel;
            frame_cnt++;
          end
          if (last_pixel) begin
            rebuild_lut();
            for (int i = 0; i < NUM_BINS; i++) hist[i] = 0;
            frame_sum = 0; frame_cnt = 0;
          end
        end
      end
    end
  end
endmodule

### test/thresholded_histogram_equalizer_tb.sv
// stimulus and verdict for the thresholded histogram equalizer
module thresholded_histogram_equalizer_tb;
  import theq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // small frame cap so the overlong frame case is reachable
  localparam int FRAME_CAP = 48;
  localparam int BUILD_WAIT = 4500;

  logic       clk, rst;
  logic       in_valid, in_ready, operation, last_pixel;
  logic [7:0] pixel;
  logic       out_valid, out_ready, last_out;
  logic [7:0] pixel_out;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         errors, pending, sent;
  bit         quiet;

  thresholded_histogram_equalizer #(.MAX_FRAME_PIXELS(FRAME_CAP)) dut (.*);

  theq_checker #(.FRAME_CAP(FRAME_CAP)) checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side stalls in bursts
  int stall_left;
  initial stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one pixel transfer, with an occasional idle burst ahead of it
  task automatic push_pixel(logic op, logic [7:0] px, logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pixel <= px;
    last_pixel <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  // drain results and let any table build finish before touching registers
  task automatic go_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (BUILD_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] ml, logic [7:0] zf, logic [7:0] lb,
                            logic [7:0] hb);
    cfg_we <= 1'b1;
    cfg_index <= REG_MEAN_LIMIT; cfg_data <= ml; @(posedge clk);
    cfg_index <= REG_ZERO_FLOOR; cfg_data <= zf; @(posedge clk);
    cfg_index <= REG_LOW_BOUND;  cfg_data <= lb; @(posedge clk);
    cfg_index <= REG_HIGH_BOUND; cfg_data <= hb; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one gather pass with occasional remaps mixed in, then a batch of remaps
  task automatic run_frame(int len, int px_lo, int px_hi, int maps);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_pixel(OP_MAP, 8'($urandom_range(0, 255)), 1'($urandom));
      push_pixel(OP_GATHER, 8'($urandom_range(px_lo, px_hi)), i == len - 1);
    end
    for (int i = 0; i < maps; i++)
      push_pixel(OP_MAP, 8'($urandom_range(0, 255)), 1'($urandom));
  endtask

  initial begin
    int lo_px, hi_px, len;
    rst = 1'b1;
    in_valid = 1'b0; operation = OP_GATHER; pixel = 8'd0; last_pixel = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_MEAN_LIMIT; cfg_data = 8'd0;
    quiet = 1'b0; sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);

    // identity table after reset, last mark on remaps
    push_pixel(OP_MAP, 8'd0, 1'b1);
    push_pixel(OP_MAP, 8'd255, 1'b0);
    push_pixel(OP_MAP, 8'd77, 1'b1);
    // dark frame with extremes of the pixel range
    push_pixel(OP_GATHER, 8'd0, 1'b0);
    push_pixel(OP_GATHER, 8'd255, 1'b0);
    push_pixel(OP_GATHER, 8'd10, 1'b0);
    push_pixel(OP_GATHER, 8'd10, 1'b1);
    push_pixel(OP_MAP, 8'd0, 1'b0);
    push_pixel(OP_MAP, 8'd10, 1'b0);
    push_pixel(OP_MAP, 8'd255, 1'b1);
    // bright single pixel: mean above limit gives identity
    push_pixel(OP_GATHER, 8'd200, 1'b1);
    push_pixel(OP_MAP, 8'd200, 1'b0);
    push_pixel(OP_MAP, 8'd5, 1'b0);
    go_idle();

    // empty band with floor above the low bound, mean limit at its maximum
    write_regs(8'd255, 8'd255, 8'd0, 8'd0);
    push_pixel(OP_GATHER, 8'd3, 1'b1);
    push_pixel(OP_MAP, 8'd254, 1'b0);
    push_pixel(OP_MAP, 8'd255, 1'b1);
    go_idle();
    write_regs(8'd0, 8'd0, 8'd255, 8'd255);
    push_pixel(OP_GATHER, 8'd0, 1'b1);
    push_pixel(OP_MAP, 8'd128, 1'b0);
    go_idle();
    // band holding no pixels: every band entry is its low edge
    write_regs(8'd255, 8'd0, 8'd100, 8'd200);
    push_pixel(OP_GATHER, 8'd20, 1'b1);
    push_pixel(OP_MAP, 8'd150, 1'b0);
    push_pixel(OP_MAP, 8'd10, 1'b0);
    go_idle();

    // random phases, including frames longer than the cap
    while (sent < 720) begin
      if (sent > 620) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: write_regs(8'd255, 8'd0, 8'd0, 8'd255);
        1: write_regs(8'd0, 8'd255, 8'd255, 8'd0);
        default: write_regs(8'($urandom), 8'($urandom_range(0, 80)),
                            8'($urandom), 8'($urandom_range(100, 255)));
      endcase
      lo_px = $urandom_range(0, 255);
      hi_px = $urandom_range(lo_px, 255);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(45, 60) : $urandom_range(1, 30);
      run_frame(len, lo_px, hi_px, $urandom_range(10, 30));
      go_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
